>>> design/qpr_pkg.sv
// Shared widths, types and rounding helpers for the quaternion product and rotate pipeline.
package qpr_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 14;

  localparam int PROD_W  = 2 * DATA_WIDTH;
  localparam int SUM_W   = PROD_W + 2;
  localparam int VPROD_W = SUM_W + DATA_WIDTH;
  localparam int ACC_W   = VPROD_W + 2;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [SUM_W-1:0]      sum_t;
  typedef logic signed [VPROD_W-1:0]    vprod_t;
  typedef logic signed [ACC_W-1:0]      acc_t;
  typedef logic signed [ACC_W:0]        wide_t;

  typedef enum logic {
    KIND_PRODUCT = 1'b0,
    KIND_ROTATE  = 1'b1
  } kind_t;

  // Component order in every quad is w, x, y, z; in every vector it is x, y, z.
  typedef struct packed {
    logic                  valid;
    kind_t                 kind;
    data_t [3:0]           a;
    data_t [3:0]           b;
  } in_t;

  typedef struct packed {
    logic                  valid;
    kind_t                 kind;
    data_t [2:0]           vec;
    prod_t [3:0][3:0]      prod;
  } s1_t;

  typedef struct packed {
    logic                  valid;
    kind_t                 kind;
    data_t [2:0]           vec;
    sum_t  [3:0]           q;
    sum_t  [2:0][2:0]      m;
  } s2_t;

  typedef struct packed {
    logic                  valid;
    kind_t                 kind;
    sum_t  [3:0]           q;
    vprod_t [2:0][2:0]     vp;
  } s3_t;

  typedef struct packed {
    logic                  valid;
    kind_t                 kind;
    acc_t  [3:0]           val;
  } s4_t;

  typedef struct packed {
    data_t                 value;
    logic                  clipped;
  } sat_t;

  localparam sum_t  ONE_M   = sum_t'(64'sd1 <<< (2 * FRAC_BITS));
  localparam wide_t HALF_Q  = wide_t'(64'sd1 <<< (FRAC_BITS - 1));
  localparam wide_t HALF_V  = wide_t'(64'sd1 <<< (2 * FRAC_BITS - 1));
  localparam wide_t DATA_HI = wide_t'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
  localparam wide_t DATA_LO = -DATA_HI - wide_t'(1);

  // Round half up at the fraction point of the given kind, then clip to the data range.
  function automatic sat_t round_sat(input acc_t v, input kind_t kind);
    wide_t t;
    wide_t r;
    sat_t  s;
    t = wide_t'(v);
    if (kind == KIND_ROTATE) begin
      r = (t + HALF_V) >>> (2 * FRAC_BITS);
    end else begin
      r = (t + HALF_Q) >>> FRAC_BITS;
    end
    if (r > DATA_HI) begin
      s.value   = DATA_HI[DATA_WIDTH-1:0];
      s.clipped = 1'b1;
    end else if (r < DATA_LO) begin
      s.value   = DATA_LO[DATA_WIDTH-1:0];
      s.clipped = 1'b1;
    end else begin
      s.value   = r[DATA_WIDTH-1:0];
      s.clipped = 1'b0;
    end
    return s;
  endfunction

endpackage

>>> design/quaternion_product_and_rotate.sv
// Top level of the fixed-point quaternion product and vector rotation pipeline.
//
// A transaction enters when start is high and busy is low at a rising clock edge.
// kind selects the operation: the Hamilton product a*b, or rotation of the vector
// (b_x, b_y, b_z) by quaternion a through its expanded rotation matrix (r_w is zero).
// All values are signed Q2.14; each component is rounded half up once and clipped to
// 16 bits, and saturated reports that any component was clipped.
//
// The block is a five-stage pipeline: products, sums and matrix entries, matrix times
// vector products, row sums, then rounding into the result registers. A transaction
// accepted at one edge shows its result with done high for exactly one cycle, once
// it has passed through every stage. One transaction can enter every cycle,
// so throughput is one per clock and busy is low whenever reset is not asserted.
// The receiver cannot hold results off; done simply pulses once per transaction.
// Reset clears every stage valid bit, so nothing in flight survives it and no result
// is shown until a new transaction has passed through.
module quaternion_product_and_rotate (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic                   kind,
  input  qpr_pkg::data_t         a_w,
  input  qpr_pkg::data_t         a_x,
  input  qpr_pkg::data_t         a_y,
  input  qpr_pkg::data_t         a_z,
  input  qpr_pkg::data_t         b_w,
  input  qpr_pkg::data_t         b_x,
  input  qpr_pkg::data_t         b_y,
  input  qpr_pkg::data_t         b_z,
  output logic                   done,
  output qpr_pkg::data_t         r_w,
  output qpr_pkg::data_t         r_x,
  output qpr_pkg::data_t         r_y,
  output qpr_pkg::data_t         r_z,
  output logic                   saturated
);

  qpr_pkg::in_t in_d;
  qpr_pkg::s1_t s1;
  qpr_pkg::s2_t s2;
  qpr_pkg::s4_t s4;

  assign busy = rst;

  always_comb begin
    in_d.valid = start & ~busy;
    in_d.kind  = qpr_pkg::kind_t'(kind);
    in_d.a[0]  = a_w;
    in_d.a[1]  = a_x;
    in_d.a[2]  = a_y;
    in_d.a[3]  = a_z;
    in_d.b[0]  = b_w;
    in_d.b[1]  = b_x;
    in_d.b[2]  = b_y;
    in_d.b[3]  = b_z;
  end

  qpr_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .in_d (in_d),
    .s1   (s1)
  );

  qpr_form u_form (
    .clk (clk),
    .rst (rst),
    .s1  (s1),
    .s2  (s2)
  );

  qpr_apply u_apply (
    .clk (clk),
    .rst (rst),
    .s2  (s2),
    .s4  (s4)
  );

  qpr_round u_round (
    .clk       (clk),
    .rst       (rst),
    .s4        (s4),
    .done      (done),
    .r_w       (r_w),
    .r_x       (r_x),
    .r_y       (r_y),
    .r_z       (r_z),
    .saturated (saturated)
  );

endmodule

>>> design/qpr_mul.sv
// First stage: all sixteen component products of a with b, or of a with itself for rotation.
module qpr_mul (
  input  logic          clk,
  input  logic          rst,
  input  qpr_pkg::in_t  in_d,
  output qpr_pkg::s1_t  s1
);

  qpr_pkg::data_t av [4];
  qpr_pkg::data_t op [4];

  // Rotation needs the squares and cross products of a, so the second operand becomes a.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      av[i] = $signed(in_d.a[i]);
      op[i] = (in_d.kind == qpr_pkg::KIND_ROTATE) ? $signed(in_d.a[i]) : $signed(in_d.b[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else begin
      s1.valid <= in_d.valid;
    end
    s1.kind <= in_d.kind;
    for (int c = 0; c < 3; c++) begin
      s1.vec[c] <= in_d.b[c+1];
    end
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        s1.prod[i][j] <= qpr_pkg::prod_t'(av[i]) * qpr_pkg::prod_t'(op[j]);
      end
    end
  end

endmodule

>>> design/qpr_form.sv
// Second stage: Hamilton product sums and the expanded rotation matrix entries.
module qpr_form (
  input  logic          clk,
  input  logic          rst,
  input  qpr_pkg::s1_t  s1,
  output qpr_pkg::s2_t  s2
);

  qpr_pkg::sum_t p [4][4];
  qpr_pkg::sum_t q [4];
  qpr_pkg::sum_t m [3][3];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        p[i][j] = qpr_pkg::sum_t'($signed(s1.prod[i][j]));
      end
    end

    q[0] = p[0][0] - p[1][1] - p[2][2] - p[3][3];
    q[1] = p[0][1] + p[1][0] + p[2][3] - p[3][2];
    q[2] = p[0][2] - p[1][3] + p[2][0] + p[3][1];
    q[3] = p[0][3] + p[1][2] - p[2][1] + p[3][0];

    // With the operand set to a: p[1][1] is xx, p[1][2] is xy, p[0][1] is wx, and so on.
    m[0][0] = qpr_pkg::ONE_M - ((p[2][2] + p[3][3]) <<< 1);
    m[0][1] = (p[1][2] - p[0][3]) <<< 1;
    m[0][2] = (p[1][3] + p[0][2]) <<< 1;
    m[1][0] = (p[1][2] + p[0][3]) <<< 1;
    m[1][1] = qpr_pkg::ONE_M - ((p[1][1] + p[3][3]) <<< 1);
    m[1][2] = (p[2][3] - p[0][1]) <<< 1;
    m[2][0] = (p[1][3] - p[0][2]) <<< 1;
    m[2][1] = (p[2][3] + p[0][1]) <<< 1;
    m[2][2] = qpr_pkg::ONE_M - ((p[1][1] + p[2][2]) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else begin
      s2.valid <= s1.valid;
    end
    s2.kind <= s1.kind;
    s2.vec  <= s1.vec;
    for (int i = 0; i < 4; i++) begin
      s2.q[i] <= q[i];
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        s2.m[r][c] <= m[r][c];
      end
    end
  end

endmodule

>>> design/qpr_apply.sv
// Third and fourth stages: matrix times vector products, then the row sums.
module qpr_apply (
  input  logic          clk,
  input  logic          rst,
  input  qpr_pkg::s2_t  s2,
  output qpr_pkg::s4_t  s4
);

  qpr_pkg::s3_t   s3;
  qpr_pkg::sum_t  me [3][3];
  qpr_pkg::data_t ve [3];
  qpr_pkg::vprod_t vp [3][3];
  qpr_pkg::acc_t  val [4];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ve[c] = $signed(s2.vec[c]);
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        me[r][c] = $signed(s2.m[r][c]);
        vp[r][c] = qpr_pkg::vprod_t'(me[r][c]) * qpr_pkg::vprod_t'(ve[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3.valid <= 1'b0;
    end else begin
      s3.valid <= s2.valid;
    end
    s3.kind <= s2.kind;
    s3.q    <= s2.q;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        s3.vp[r][c] <= vp[r][c];
      end
    end
  end

  // A rotation reports w as zero; a product carries its four sums on unchanged.
  always_comb begin
    if (s3.kind == qpr_pkg::KIND_ROTATE) begin
      val[0] = '0;
      for (int r = 0; r < 3; r++) begin
        val[r+1] = qpr_pkg::acc_t'($signed(s3.vp[r][0]))
                 + qpr_pkg::acc_t'($signed(s3.vp[r][1]))
                 + qpr_pkg::acc_t'($signed(s3.vp[r][2]));
      end
    end else begin
      for (int i = 0; i < 4; i++) begin
        val[i] = qpr_pkg::acc_t'($signed(s3.q[i]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4.valid <= 1'b0;
    end else begin
      s4.valid <= s3.valid;
    end
    s4.kind <= s3.kind;
    for (int i = 0; i < 4; i++) begin
      s4.val[i] <= val[i];
    end
  end

endmodule

>>> design/qpr_round.sv
// Fifth stage: rounding, saturation and the result registers.
module qpr_round (
  input  logic            clk,
  input  logic            rst,
  input  qpr_pkg::s4_t    s4,
  output logic            done,
  output qpr_pkg::data_t  r_w,
  output qpr_pkg::data_t  r_x,
  output qpr_pkg::data_t  r_y,
  output qpr_pkg::data_t  r_z,
  output logic            saturated
);

  qpr_pkg::sat_t rs [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rs[i] = qpr_pkg::round_sat($signed(s4.val[i]), s4.kind);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s4.valid;
    end
  end

  always_ff @(posedge clk) begin
    r_w       <= rs[0].value;
    r_x       <= rs[1].value;
    r_y       <= rs[2].value;
    r_z       <= rs[3].value;
    saturated <= rs[0].clipped | rs[1].clipped | rs[2].clipped | rs[3].clipped;
  end

endmodule
